/* design/msct_pkg.sv */
// Shared types and codes for the multi-slot countdown timer unit.
package msct_pkg;

	localparam int unsigned SLOTS_DEF       = 16;
	localparam int unsigned COUNT_WIDTH_DEF = 16;
	localparam int unsigned MASK_BITS       = 16;
	localparam int unsigned SLOT_OUT_BITS   = 4;
	localparam int unsigned ID_BITS         = 5;
	localparam int unsigned SECONDS_BITS    = 16;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_ADD     = 2'd1,
		CMD_CANCEL  = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_FREE     = 2'd0,
		PH_RUNNING  = 2'd1,
		PH_CANCELED = 2'd2,
		PH_OVER     = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOSPACE  = 3'd1,
		ST_INVALID  = 3'd2,
		ST_CANCELED = 3'd3,
		ST_OVER     = 3'd4,
		ST_RUNNING  = 3'd5
	} status_t;

	// per-slot update strobes, at most one set per cycle
	typedef struct packed {
		logic tick;
		logic add;
		logic cancel;
		logic release_job;
	} slot_ctl_t;

	typedef struct packed {
		logic   used;
		phase_t phase;
		logic   fire;
	} slot_stat_t;

endpackage

/* design/multi_slot_countdown_timer_unit.sv */
// Top level of the multi-slot countdown timer unit.
// A table of SLOTS one-shot countdown jobs driven by a request stream. Each request is
// a tick, an add, a cancel or a release, and each one returns exactly one response
// with a status, a slot index and, for ticks, the mask of slots that fired. Requests
// are taken one per clock cycle when the response side keeps up; each request passes
// through the input register and then into the response register, and the
// slot table is updated as the request leaves the input register, so the next request
// already sees its effect. A tick counts down all running slots in parallel; a slot
// added with zero or one fires on the first tick. Add takes the lowest free slot,
// found by a priority encoder across the table in the same cycle. Slots past the
// sixteenth still run but have no bit in fired_mask, and slot_index carries the low
// four bits of the slot number. No clearing pass is needed after reset.
module multi_slot_countdown_timer_unit #(
	parameter int unsigned SLOTS       = msct_pkg::SLOTS_DEF,
	parameter int unsigned COUNT_WIDTH = msct_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // command[1:0], job_id[6:2], seconds[22:7], zero[23]
	// response channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // status[2:0], slot_index[6:3], fired_mask[22:7], zero[23]
);

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// ---------------- input register ----------------
	logic                                  valid_s1;
	msct_pkg::cmd_t                        cmd_s1;
	logic [msct_pkg::ID_BITS-1:0]          id_s1;
	logic [msct_pkg::SECONDS_BITS-1:0]     secs_s1;
	logic                                  go;   // request in s1 is processed now

	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= msct_pkg::cmd_t'(s_tdata[1:0]);
			id_s1   <= s_tdata[6:2];
			secs_s1 <= s_tdata[22:7];
		end
	end

	// ---------------- slot table ----------------
	msct_pkg::slot_stat_t stat [SLOTS];
	logic [SLOTS-1:0]     free_slots;
	logic [SLOTS-1:0]     hit;        // one-hot on the addressed slot when id is in range
	logic [SLOTS-1:0]     grant;
	logic                 found;
	logic [IDX_W-1:0]     alloc_idx;
	logic                 id_ok;
	logic                 do_cancel;
	logic                 do_release;
	logic [COUNT_WIDTH-1:0] load;
	logic [COUNT_WIDTH+msct_pkg::SECONDS_BITS-1:0] secs_ext;

	// seconds cut or zero-extended to the counter width
	assign secs_ext = {{COUNT_WIDTH{1'b0}}, secs_s1};
	assign load     = secs_ext[COUNT_WIDTH-1:0];
	assign id_ok    = (32'(id_s1) < SLOTS);

	for (genvar i = 0; i < SLOTS; i++) begin : g_slot
		msct_pkg::slot_ctl_t ctl;

		assign free_slots[i] = !stat[i].used;
		assign hit[i]        = id_ok && (32'(id_s1) == i);

		assign ctl.tick        = go && (cmd_s1 == msct_pkg::CMD_TICK);
		assign ctl.add         = go && (cmd_s1 == msct_pkg::CMD_ADD) && grant[i];
		assign ctl.cancel      = do_cancel && hit[i];
		assign ctl.release_job = do_release && hit[i];

		msct_slot #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.load   (load),
			.stat   (stat[i])
		);
	end

	msct_alloc #(
		.SLOTS(SLOTS)
	) u_alloc (
		.free_slots (free_slots),
		.found      (found),
		.grant      (grant),
		.idx        (alloc_idx)
	);

	// addressed slot read through the one-hot hit vector
	logic             sel_used;
	msct_pkg::phase_t sel_phase;

	always_comb begin
		sel_used  = 1'b0;
		sel_phase = msct_pkg::PH_FREE;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit[i]) begin
				sel_used  = stat[i].used;
				sel_phase = stat[i].phase;
			end
		end
	end

	// ---------------- response decode ----------------
	msct_pkg::status_t                    status;
	logic [msct_pkg::SLOT_OUT_BITS-1:0]   slot_out;
	logic [msct_pkg::MASK_BITS-1:0]       fired;
	logic [IDX_W+msct_pkg::SLOT_OUT_BITS-1:0] idx_ext;

	assign idx_ext = {{msct_pkg::SLOT_OUT_BITS{1'b0}}, alloc_idx};

	for (genvar b = 0; b < msct_pkg::MASK_BITS; b++) begin : g_mask
		if (b < SLOTS) begin : g_on
			assign fired[b] = (cmd_s1 == msct_pkg::CMD_TICK) && stat[b].fire;
		end else begin : g_off
			assign fired[b] = 1'b0;
		end
	end

	always_comb begin
		status     = msct_pkg::ST_OK;
		slot_out   = '0;
		do_cancel  = 1'b0;
		do_release = 1'b0;
		unique case (cmd_s1)
			msct_pkg::CMD_TICK: begin
				status = msct_pkg::ST_OK;
			end
			msct_pkg::CMD_ADD: begin
				if (found) begin
					slot_out = idx_ext[msct_pkg::SLOT_OUT_BITS-1:0];
				end else begin
					status = msct_pkg::ST_NOSPACE;
				end
			end
			msct_pkg::CMD_CANCEL: begin
				slot_out = id_s1[msct_pkg::SLOT_OUT_BITS-1:0];
				if (!id_ok || !sel_used)
					status = msct_pkg::ST_INVALID;
				else if (sel_phase == msct_pkg::PH_CANCELED)
					status = msct_pkg::ST_CANCELED;
				else if (sel_phase == msct_pkg::PH_OVER)
					status = msct_pkg::ST_OVER;
				else
					do_cancel = go;
			end
			msct_pkg::CMD_RELEASE: begin
				slot_out = id_s1[msct_pkg::SLOT_OUT_BITS-1:0];
				if (!id_ok || !sel_used)
					status = msct_pkg::ST_INVALID;
				else if (sel_phase == msct_pkg::PH_RUNNING)
					status = msct_pkg::ST_RUNNING;
				else
					do_release = go;
			end
			default: begin
				status = msct_pkg::ST_OK;
			end
		endcase
	end

	// ---------------- response register ----------------
	logic                               out_valid_q;
	msct_pkg::status_t                  status_q;
	logic [msct_pkg::SLOT_OUT_BITS-1:0] slot_q;
	logic [msct_pkg::MASK_BITS-1:0]     fired_q;

	// s1 moves on when the response register is empty or being drained
	assign go = valid_s1 && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (go)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_q <= status;
			slot_q   <= slot_out;
			fired_q  <= fired;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, fired_q, slot_q, status_q};

endmodule

/* design/msct_slot.sv */
// One timer slot: phase and countdown register with its update rules.
module msct_slot #(
	parameter int unsigned COUNT_WIDTH = msct_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  msct_pkg::slot_ctl_t    ctl,
	input  logic [COUNT_WIDTH-1:0] load,
	output msct_pkg::slot_stat_t   stat
);

	msct_pkg::phase_t       phase_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   running;
	logic                   fire;

	assign running = (phase_q == msct_pkg::PH_RUNNING);
	// zero or one left: this tick ends the job
	assign fire    = ctl.tick && running && (cnt_q <= COUNT_WIDTH'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= msct_pkg::PH_FREE;
			cnt_q   <= '0;
		end else if (ctl.add) begin
			phase_q <= msct_pkg::PH_RUNNING;
			cnt_q   <= load;
		end else if (ctl.cancel) begin
			phase_q <= msct_pkg::PH_CANCELED;
		end else if (ctl.release_job) begin
			phase_q <= msct_pkg::PH_FREE;
			cnt_q   <= '0;
		end else if (ctl.tick && running) begin
			if (cnt_q != '0)
				cnt_q <= cnt_q - COUNT_WIDTH'(1);
			if (fire)
				phase_q <= msct_pkg::PH_OVER;
		end
	end

	assign stat.used  = (phase_q != msct_pkg::PH_FREE);
	assign stat.phase = phase_q;
	assign stat.fire  = fire;

endmodule

/* design/msct_alloc.sv */
// Lowest-free-slot finder for the add command.
module msct_alloc #(
	parameter int unsigned SLOTS = msct_pkg::SLOTS_DEF,
	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic [SLOTS-1:0] free_slots,
	output logic             found,
	output logic [SLOTS-1:0] grant,
	output logic [IDX_W-1:0] idx
);

	// isolate lowest set bit
	assign grant = free_slots & ~(free_slots - SLOTS'(1));
	assign found = |free_slots;

	always_comb begin
		idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (grant[i])
				idx = idx | IDX_W'(i);
		end
	end

endmodule
